/* rtl/core/pkwra_pkg.sv */
// shared types and constants of the per-key window rate alarm
// no dependencies; used by every module of the block but pkwra_ram
`timescale 1ns / 1ps

package pkwra_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_NS      = 1'b1;

  localparam logic [CFG_W-1:0]   RESET_THRESHOLD = 32'd100;
  localparam logic [CFG_W-1:0]   RESET_WINDOW    = 32'd1000000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE       = 32'd1;

  typedef struct packed {
    logic [KEY_W-1:0]  event_key;
    logic [TIME_W-1:0] event_time;
  } event_t;

  typedef struct packed {
    logic [KEY_W-1:0]   alarm_key;
    logic [COUNT_W-1:0] alarm_count;
  } alarm_t;

  // one table row as stored in the entry memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  start;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] rate_threshold;
    logic [CFG_W-1:0] window_ns;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_INSERT
  } state_e;

endpackage

/* rtl/core/per_key_window_rate_alarm_top.sv */
// top level of the per-key window rate alarm: scan fsm, entry table, alarm output
// depends on pkwra_pkg, pkwra_ram and pkwra_cfg
`timescale 1ns / 1ps

// Per-key fixed-window rate alarm. Each event (key, timestamp) is taken on a
// start beat while busy is low. The block walks its entry table, one stored
// entry per cycle through the single read port of the entry ram, looking for
// the key. A known key whose window has lasted at least window_ns closes the
// window: if the closed count is at or above rate_threshold, one alarm beat
// (key, count) follows, then the window restarts with count 1; otherwise the
// count is bumped, saturating at all ones. An unknown key is appended at the
// next free row with count 1; when the table is full the event is dropped.
// Rows are never evicted and the table fills in order, so a fill counter
// stands in for per-row valid bits and no clearing pass is needed after
// reset. An event keeps busy high while the block walks the rows in use
// (at most TABLE_ENTRIES) and then writes the hit row back or appends the
// new one; a hit ends the walk at its row, a dropped event on a full table
// skips the write, and a new key on an empty table is appended with no
// walk. The alarm beat shows on alarm_valid_o for exactly one cycle, the
// first cycle with busy low after the event; the receiver cannot stall it,
// and a new event may already be started in that same cycle.
// Configuration writes are taken at any cycle and are meant for idle periods.
module per_key_window_rate_alarm_top #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // event command port
  input  logic                            start,
  output logic                            busy,
  input  pkwra_pkg::event_t               event_i,
  // alarm strobe port
  output logic                            alarm_valid_o,
  output pkwra_pkg::alarm_t               alarm_o,
  // register write port
  input  logic                            cfg_we_i,
  input  logic [pkwra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pkwra_pkg::CFG_W-1:0]     cfg_wdata_i
);

  // row address width and a counter width that can also hold TABLE_ENTRIES
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  pkwra_pkg::cfg_t   cfg;
  pkwra_pkg::state_e state_q, state_d;

  // rows in use; rows below fill_q are valid
  logic [CW-1:0] fill_q, fill_d;
  // next row to read during the walk
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] prev_idx;

  pkwra_pkg::event_t evt_q, evt_d;
  pkwra_pkg::entry_t hit_q, hit_d;
  logic [AW-1:0]     hit_idx_q, hit_idx_d;

  logic              out_valid_q, out_valid_d;
  pkwra_pkg::alarm_t out_q, out_d;

  // entry ram ports
  logic              ram_re, ram_we;
  logic [AW-1:0]     ram_raddr, ram_waddr;
  pkwra_pkg::entry_t ram_wdata, ram_rdata;

  logic [pkwra_pkg::TIME_W-1:0] elapsed;
  logic                         win_closed;

  pkwra_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pkwra_ram #(
    .WIDTH ($bits(pkwra_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // row whose read data is on ram_rdata during the walk
  assign prev_idx = ptr_q - CW'(1);

  // window test on the latched hit row
  assign elapsed    = evt_q.event_time - hit_q.start;
  assign win_closed = (elapsed >= {{(pkwra_pkg::TIME_W - pkwra_pkg::CFG_W){1'b0}},
                                   cfg.window_ns});

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    evt_d       = evt_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    out_valid_d = 1'b0;
    out_d       = out_q;

    ram_re    = 1'b0;
    ram_raddr = ptr_q[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = fill_q[AW-1:0];
    // fresh row: window starts at the event, count 1
    ram_wdata.key   = evt_q.event_key;
    ram_wdata.start = evt_q.event_time;
    ram_wdata.count = pkwra_pkg::COUNT_ONE;

    case (state_q)
      pkwra_pkg::ST_IDLE: begin
        if (start) begin
          evt_d = event_i;
          if (fill_q == '0) begin
            state_d = pkwra_pkg::ST_INSERT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            ptr_d     = CW'(1);
            state_d   = pkwra_pkg::ST_SCAN;
          end
        end
      end

      pkwra_pkg::ST_SCAN: begin
        if (ram_rdata.key == evt_q.event_key) begin
          hit_d     = ram_rdata;
          hit_idx_d = prev_idx[AW-1:0];
          state_d   = pkwra_pkg::ST_UPDATE;
        end else if (ptr_q == fill_q) begin
          // walked every valid row without a match
          if (fill_q == FULL_COUNT) begin
            state_d = pkwra_pkg::ST_IDLE;
          end else begin
            state_d = pkwra_pkg::ST_INSERT;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[AW-1:0];
          ptr_d     = ptr_q + CW'(1);
        end
      end

      pkwra_pkg::ST_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx_q;
        if (win_closed) begin
          out_valid_d       = (hit_q.count >= cfg.rate_threshold);
          out_d.alarm_key   = evt_q.event_key;
          out_d.alarm_count = hit_q.count;
        end else begin
          ram_wdata.start = hit_q.start;
          ram_wdata.count = (hit_q.count == pkwra_pkg::COUNT_MAX) ?
                            hit_q.count : hit_q.count + pkwra_pkg::COUNT_ONE;
        end
        state_d = pkwra_pkg::ST_IDLE;
      end

      pkwra_pkg::ST_INSERT: begin
        ram_we  = 1'b1;
        fill_d  = fill_q + CW'(1);
        state_d = pkwra_pkg::ST_IDLE;
      end

      default: begin
        state_d = pkwra_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pkwra_pkg::ST_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    evt_q     <= evt_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    out_q     <= out_d;
  end

  assign busy          = (state_q != pkwra_pkg::ST_IDLE);
  assign alarm_valid_o = out_valid_q;
  assign alarm_o       = out_q;

endmodule

/* rtl/core/pkwra_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pkwra_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pkwra_cfg.sv */
// configuration registers: rate threshold and window length
// depends on pkwra_pkg
`timescale 1ns / 1ps

module pkwra_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pkwra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pkwra_pkg::CFG_W-1:0]     cfg_wdata_i,
  output pkwra_pkg::cfg_t                 cfg_o
);

  pkwra_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pkwra_pkg::CFG_RATE_THRESHOLD: cfg_d.rate_threshold = cfg_wdata_i;
        pkwra_pkg::CFG_WINDOW_NS:      cfg_d.window_ns      = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_threshold <= pkwra_pkg::RESET_THRESHOLD;
      cfg_q.window_ns      <= pkwra_pkg::RESET_WINDOW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/pkwra_checker.sv */
// port-level checker for the per-key window rate alarm, bound to the top level
// depends on pkwra_pkg and per_key_window_rate_alarm_top
`timescale 1ns / 1ps

module pkwra_assert (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            alarm_valid_o,
  input pkwra_pkg::alarm_t               alarm_o
);

  // an accepted event always occupies the block for a while
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted event did not raise busy");

  // an alarm beat only follows the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_valid_o |-> (!busy && $past(busy)))
    else $error("alarm beat outside the end of an event");

  // no two alarm beats in a row; each event raises at most one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_valid_o |=> !alarm_valid_o)
    else $error("two alarm beats in a row");

  // a raised alarm carries a count of at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_valid_o |-> (alarm_o.alarm_count != '0))
    else $error("alarm with zero count");

endmodule

bind per_key_window_rate_alarm_top pkwra_assert u_pkwra_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .alarm_valid_o (alarm_valid_o),
  .alarm_o       (alarm_o)
);

/* sim/pkwra_checker.sv */
// alarm checker for the per-key window rate alarm: tracks the event table, predicts alarms
// depends on pkwra_pkg; watches the event, alarm and register ports of the block
`timescale 1ns / 1ps

module pkwra_checker
  import pkwra_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  event_t               event_i,
  input  logic                 alarm_valid_i,
  input  alarm_t               alarm_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          events_o,
  output int unsigned          alarms_o,
  output int unsigned          rows_used_o
);

  // rows are never evicted, so they fill in order
  logic [KEY_W-1:0]   row_key   [TABLE_ENTRIES];
  logic [TIME_W-1:0]  row_start [TABLE_ENTRIES];
  logic [COUNT_W-1:0] row_count [TABLE_ENTRIES];
  logic [CFG_W-1:0]   threshold_q;
  logic [CFG_W-1:0]   window_q;
  alarm_t             expected_alarms[$];

  task automatic flag(input string what);
    if (fail_count_o < 10) $display("alarm mismatch at %0t: %s", $time, what);
    fail_count_o++;
  endtask

  // updates the table for one event, returns 1 when a closing window raises an alarm
  function automatic bit track_event(input event_t ev, output alarm_t al);
    int                hit;
    logic [TIME_W-1:0] elapsed;
    hit = -1;
    al  = '0;
    for (int r = 0; r < rows_used_o; r++) begin
      if (hit < 0 && row_key[r] == ev.event_key) hit = r;
    end
    if (hit < 0) begin
      // insert never alarms; a full table drops the event
      if (rows_used_o < TABLE_ENTRIES) begin
        row_key[rows_used_o]   = ev.event_key;
        row_start[rows_used_o] = ev.event_time;
        row_count[rows_used_o] = COUNT_ONE;
        rows_used_o++;
      end
      return 1'b0;
    end
    elapsed = ev.event_time - row_start[hit];
    if (elapsed >= {32'd0, window_q}) begin
      al.alarm_key   = ev.event_key;
      al.alarm_count = row_count[hit];
      row_start[hit] = ev.event_time;
      row_count[hit] = COUNT_ONE;
      return al.alarm_count >= threshold_q;
    end
    if (row_count[hit] != COUNT_MAX) row_count[hit] = row_count[hit] + COUNT_ONE;
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alarm_t want;
    if (!rst_ni) begin
      rows_used_o  = 0;
      threshold_q  = RESET_THRESHOLD;
      window_q     = RESET_WINDOW;
      fail_count_o = 0;
      events_o     = 0;
      alarms_o     = 0;
      expected_alarms.delete();
    end else begin
      if (alarm_valid_i) begin
        alarms_o++;
        if (expected_alarms.size() == 0) begin
          flag($sformatf("unexpected alarm key %h count %0d",
                         alarm_i.alarm_key, alarm_i.alarm_count));
        end else begin
          want = expected_alarms.pop_front();
          if (alarm_i.alarm_key !== want.alarm_key)
            flag($sformatf("alarm_key expected %h, got %h", want.alarm_key, alarm_i.alarm_key));
          if (alarm_i.alarm_count !== want.alarm_count)
            flag($sformatf("alarm_count of key %h expected %0d, got %0d",
                           want.alarm_key, want.alarm_count, alarm_i.alarm_count));
        end
      end
      if (start_i && !busy_i) begin
        events_o++;
        if (track_event(event_i, want)) expected_alarms.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RATE_THRESHOLD: threshold_q = cfg_wdata_i;
          CFG_WINDOW_NS:      window_q    = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_alarms.size();
  end

endmodule

/* sim/tb_per_key_window_rate_alarm_top.sv */
// regression bench for per_key_window_rate_alarm_top: directed corners, then random event loads
// depends on pkwra_pkg, the block's rtl and pkwra_checker, which predicts and compares alarms
`timescale 1ns / 1ps

module tb_per_key_window_rate_alarm_top;
  import pkwra_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 256;
  // one event walks at most the whole table, plus a little slack
  localparam int unsigned SETTLE_CYCLES = TABLE_ENTRIES + 8;
  // cycles with no beat on either side before the run is declared hung
  localparam int unsigned QUIET_LIMIT   = 5000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  event_t               event_i;
  logic                 alarm_valid_o;
  alarm_t               alarm_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          events_taken;
  int unsigned          alarms_taken;
  int unsigned          rows_used;
  int unsigned          quiet_cycles = 0;
  int unsigned          settings_run = 0;

  // event time shared by all keys in the random loads, stepped on each event
  logic [TIME_W-1:0]    wall_ns;
  // keys that come back often; the first four are fixed corner patterns
  logic [KEY_W-1:0]     key_pool [16];

  per_key_window_rate_alarm_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .event_i      (event_i),
    .alarm_valid_o(alarm_valid_o),
    .alarm_o      (alarm_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  pkwra_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) alarm_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .event_i      (event_i),
    .alarm_valid_i(alarm_valid_o),
    .alarm_i      (alarm_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .events_o     (events_taken),
    .alarms_o     (alarms_taken),
    .rows_used_o  (rows_used)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: any event or alarm beat counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || alarm_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no progress for %0d cycles", QUIET_LIMIT);
      $display("per_key_window_rate_alarm_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one event beat; start stays high when the next beat follows with no gap
  task automatic send_event(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp,
                            input int unsigned gap);
    event_i <= '{event_key: key, event_time: stamp};
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender holds off until every predicted alarm is in and the table walk is over
  task automatic settle();
    start <= 1'b0;
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers are rewritten on every change of setting, only while idle
  task automatic set_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] win);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RATE_THRESHOLD;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_WINDOW_NS;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_run++;
  endtask

  // random load under one setting: hot keys revisited with time steps sized to
  // the window, so windows both grow and close; some steps land on the window
  // edge, some jump anywhere or step back to exercise the wrapped elapsed time
  task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] win,
                           input int unsigned items, input int unsigned hot,
                           input int unsigned new_pct, input int unsigned gap_pct);
    logic [KEY_W-1:0] key;
    int unsigned      roll;
    int unsigned      gap;
    set_regs(thr, win);
    for (int unsigned n = 0; n < items; n++) begin
      key = key_pool[$urandom_range(0, hot - 1)];
      if ($urandom_range(0, 99) < new_pct) key = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 62)      wall_ns += $urandom_range(0, win >> 3);
      else if (roll < 78) wall_ns += 64'(win) + $urandom_range(0, win);
      else if (roll < 88) wall_ns += 64'(win) - $urandom_range(0, 1);
      else if (roll < 94) wall_ns = {$urandom(), $urandom()};
      else                wall_ns -= $urandom_range(1, 1000);
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 3);
      send_event(key, wall_ns, gap);
    end
  endtask

  initial begin
    start       <= 1'b0;
    event_i     <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_RATE_THRESHOLD;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h5555_5555;
    key_pool[3] = 32'hAAAA_AAAA;
    for (int k = 4; k < 16; k++) key_pool[k] = $urandom();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: threshold 100, one second window
    send_event(key_pool[0], 64'd0, 0);                  // insert into empty table
    send_event(key_pool[1], '1, 1);                     // insert, time at all ones
    send_event(key_pool[0], 64'd999_999_999, 0);        // one short of the window
    send_event(key_pool[0], 64'd1_000_000_000, 2);      // exactly the window, count below threshold
    send_event(key_pool[1], 64'd5, 0);                  // time wrapped past zero, small elapsed
    send_event(key_pool[0], 64'd3, 0);                  // time went back, looks like a long wait

    // zero threshold: every closing window alarms, inserts stay quiet
    set_regs('0, 32'd1);
    send_event(key_pool[0], 64'd3, 0);                  // zero elapsed, count grows
    send_event(key_pool[0], 64'd4, 0);                  // closes with count 2
    send_event(key_pool[1], 64'd6, 3);                  // wrapped window closes
    send_event(key_pool[2], 64'hAAAA_AAAA_AAAA_AAAA, 0);
    send_event(key_pool[3], 64'h5555_5555_5555_5555, 0);

    // zero window: every hit closes its window
    set_regs(32'd1, '0);
    send_event(key_pool[0], 64'd4, 0);
    send_event(key_pool[0], 64'd4, 1);
    send_event(key_pool[2], 64'd0, 0);

    // both registers at their maximum: no alarm short of a saturated count
    set_regs('1, '1);
    send_event(key_pool[0], 64'd4 + 64'hFFFF_FFFE, 0);  // one short of the longest window
    send_event(key_pool[0], 64'd4 + 64'hFFFF_FFFF, 0);  // closes, count 2 stays quiet
    send_event(key_pool[3], '0, 0);                     // wrapped, closes quietly

    wall_ns = {$urandom(), $urandom()};
    run_phase(32'd4,    32'd64,        150, 6,  2,  30);
    run_phase('0,       32'd1,         100, 4,  2,  20);
    run_phase(32'd1,    '0,            80,  8,  0,  30);
    run_phase(32'd2,    32'd1000,      150, 12, 0,  0);   // a stretch with no gaps
    run_phase('1,       32'd500,       60,  6,  0,  30);
    run_phase(32'd3,    '1,            100, 6,  0,  20);
    // mostly new keys: fills the table and runs past it into dropped events
    run_phase(32'd2,    32'd32,        320, 16, 80, 10);
    run_phase(32'd5,    32'd200,       150, 10, 8,  30);
    // back to the reset setting, sender never pauses to the end
    run_phase(RESET_THRESHOLD, RESET_WINDOW, 150, 4, 5, 0);

    settle();
    $display("run covered %0d events under %0d register settings, %0d alarms checked",
             events_taken, settings_run, alarms_taken);
    $display("table rows in use at the end: %0d of %0d", rows_used, TABLE_ENTRIES);
    if (fail_count == 0 && pending == 0) begin
      $display("per_key_window_rate_alarm_top regression: pass");
    end else begin
      $display("per_key_window_rate_alarm_top regression: fail");
    end
    $finish;
  end

endmodule
